// File: rtl/qrsef_pkg.sv
// Shared constants for the QRS enhancement filter chain.
// Used by qrs_enhance_filter_chain; depends on nothing else.

package qrsef_pkg;

   localparam int DEF_MAX_PRODUCT_LEN = 5;
   localparam int DEF_MAX_HALF_WINDOW = 50;
   localparam int DEF_SAMPLE_BITS     = 16;

   localparam int TAPS      = 13;
   localparam int TAP_MID   = 6;
   localparam int SEEN_W    = 3;
   localparam int WIN_DEPTH = 128;
   localparam int WIN_AW    = 7;
   localparam int VALUE_W   = 32;

   localparam int LEN_W      = 3;
   localparam int HALF_W     = 6;
   localparam int CSR_DATA_W = 6;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PRODUCT_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HALF    = 1'd1;

   localparam logic [LEN_W-1:0]  PRODUCT_LENGTH_RESET = 3'd3;
   localparam logic [HALF_W-1:0] WINDOW_HALF_RESET    = 6'd18;

endpackage

// File: rtl/qrs_enhance_filter_chain.sv
// QRS enhancement chain: second difference, product of derivatives, moving-window integration.
// Depends on qrsef_pkg; holds the integration window in a single-port-write, registered-read RAM.

// One result leaves per sample, centered, once its right-hand context has arrived; the final
// sample of a record flushes all pending results, the last one marked. A sample passes through
// the difference, product-shift, multiply, window-read, sum, divide and output states; the
// multiply loop steps once per factor of the product length, and the divider, on a window
// span 7 bits wide by default, retires two quotient bits per cycle. A result waits while
// rsp_ready holds off the previous one. Each flushed position takes the same sequence minus the
// stages it skips. Product length and window half are latched at a record's first sample.
module qrs_enhance_filter_chain #(
   parameter int MAX_PRODUCT_LEN = qrsef_pkg::DEF_MAX_PRODUCT_LEN,
   parameter int MAX_HALF_WINDOW = qrsef_pkg::DEF_MAX_HALF_WINDOW,
   parameter int SAMPLE_BITS     = qrsef_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [qrsef_pkg::VALUE_W-1:0]        rsp_value,
   output logic                                 rsp_last_res,
   input  logic                                 csr_wr_en,
   input  logic [qrsef_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qrsef_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DW        = SAMPLE_BITS + 2;
   localparam int LW        = $clog2(MAX_PRODUCT_LEN + 1);
   localparam int KW        = (MAX_PRODUCT_LEN > 1) ? $clog2(MAX_PRODUCT_LEN) : 1;
   localparam int HW        = $clog2(MAX_HALF_WINDOW + 1);
   localparam int SPAN_W    = HW + 1;
   localparam int SUM_W     = qrsef_pkg::VALUE_W + SPAN_W;
   localparam int PROD_W    = qrsef_pkg::VALUE_W + DW;
   localparam int DIV_STEPS = (SUM_W + 1) / 2;
   localparam int DIV_W     = 2 * DIV_STEPS;
   localparam int DCW       = $clog2(DIV_STEPS);
   localparam int CNT_MAX   = (MAX_HALF_WINDOW > qrsef_pkg::TAP_MID) ?
                              MAX_HALF_WINDOW : qrsef_pkg::TAP_MID;
   localparam int CNT_W     = $clog2(CNT_MAX + 1);
   localparam int VW        = qrsef_pkg::VALUE_W;
   localparam int AW        = qrsef_pkg::WIN_AW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_PSHIFT, ST_PMUL, ST_INT_RD, ST_INT_SUM, ST_DIV, ST_OUT, ST_SEQ
   } state_type;

   typedef enum logic [1:0] {PH_SAMPLE, PH_DIFF, PH_PROD, PH_INT} phase_type;

   state_type state_ff;
   phase_type phase_ff;

   logic [qrsef_pkg::LEN_W-1:0]  product_length_ff;
   logic [qrsef_pkg::HALF_W-1:0] window_half_ff;

   logic signed [SAMPLE_BITS-1:0] samp_ff [qrsef_pkg::TAPS];
   logic signed [DW-1:0]          dl_ff [MAX_PRODUCT_LEN];
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [DW-1:0]          d_ff;
   logic                          last_ff;
   logic                          in_record_ff;
   logic [LW-1:0]                 act_len_ff;
   logic [HW-1:0]                 act_half_ff;
   logic [SPAN_W-1:0]             span_ff;
   logic [qrsef_pkg::SEEN_W-1:0]  samples_seen_ff;
   logic [LW-1:0]                 deriv_seen_ff;
   logic [LW-1:0]                 jp_ff;
   logic [LW-1:0]                 k_ff;
   logic [SPAN_W-1:0]             prod_seen_ff;
   logic [AW-1:0]                 ring_ff;
   logic [SUM_W-1:0]              running_sum_ff;
   logic [CNT_W-1:0]              flush_left_ff;
   logic [VW-1:0]                 mag_ff;
   logic [DIV_W-1:0]              quot_ff;
   logic [SPAN_W-1:0]             rem_ff;
   logic [DCW-1:0]                div_cnt_ff;
   logic                          rsp_valid_ff;
   logic [VW-1:0]                 rsp_value_ff;
   logic                          rsp_last_ff;

   logic [VW-1:0] win_mem [qrsef_pkg::WIN_DEPTH];
   logic [VW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          win_we;

   logic signed [DW-1:0] d_in;
   logic [DW-1:0]        a_mag;
   logic [PROD_W-1:0]    prod_full;
   logic [VW-1:0]        mag_in;
   logic [SUM_W-1:0]     sum_in;
   logic [DIV_W-1:0]     quot_in;
   logic [SPAN_W-1:0]    rem_in;
   logic [LW-1:0]        half_len;
   logic                 fin;
   logic [LW-1:0]        len_sat;
   logic [HW-1:0]        half_sat;

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_last_res = rsp_last_ff;

   assign half_len = act_len_ff >> 1;
   assign rd_addr  = ring_ff - AW'(span_ff);
   assign win_we   = (state_ff == ST_INT_RD);

   always_comb begin
      if (product_length_ff == '0) begin
         len_sat = LW'(1);
      end else if (product_length_ff > qrsef_pkg::LEN_W'(MAX_PRODUCT_LEN)) begin
         len_sat = LW'(MAX_PRODUCT_LEN);
      end else begin
         len_sat = LW'(product_length_ff);
      end
      if (window_half_ff > qrsef_pkg::HALF_W'(MAX_HALF_WINDOW)) begin
         half_sat = HW'(MAX_HALF_WINDOW);
      end else begin
         half_sat = HW'(window_half_ff);
      end
   end

   assign d_in = DW'(x_ff) - (DW'(samp_ff[qrsef_pkg::TAP_MID-1]) <<< 1)
                 + DW'(samp_ff[qrsef_pkg::TAPS-2]);

   assign a_mag     = dl_ff[k_ff[KW-1:0]][DW-1] ? DW'(-dl_ff[k_ff[KW-1:0]])
                                                : DW'(dl_ff[k_ff[KW-1:0]]);
   assign prod_full = PROD_W'(mag_ff) * PROD_W'(a_mag);
   assign mag_in    = (|prod_full[PROD_W-1:VW]) ? '1 : prod_full[VW-1:0];

   assign sum_in = running_sum_ff + SUM_W'(mag_ff)
                   - ((prod_seen_ff == span_ff) ? SUM_W'(rd_data_ff) : '0);

   always_comb begin
      logic [SPAN_W:0]   trial;
      logic [DIV_W-1:0]  q_v;
      logic [SPAN_W-1:0] r_v;
      q_v = quot_ff;
      r_v = rem_ff;
      for (int i = 0; i < 2; i++) begin
         trial = {r_v, q_v[DIV_W-1]};
         q_v   = q_v << 1;
         if (trial >= {1'b0, span_ff}) begin
            trial  = trial - {1'b0, span_ff};
            q_v[0] = 1'b1;
         end
         r_v = trial[SPAN_W-1:0];
      end
      quot_in = q_v;
      rem_in  = r_v;
   end

   assign fin = last_ff && (((phase_ff == PH_INT) && (flush_left_ff == '0))
                || ((phase_ff == PH_PROD) && (flush_left_ff == '0) && (act_half_ff == '0))
                || ((phase_ff == PH_DIFF) && (flush_left_ff == '0) && (half_len == '0)
                    && (act_half_ff == '0)));

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[ring_ff] <= mag_ff;
      end
      rd_data_ff <= win_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         product_length_ff <= qrsef_pkg::PRODUCT_LENGTH_RESET;
         window_half_ff    <= qrsef_pkg::WINDOW_HALF_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            qrsef_pkg::CSR_PRODUCT_LENGTH: product_length_ff <= csr_wdata[qrsef_pkg::LEN_W-1:0];
            qrsef_pkg::CSR_WINDOW_HALF:    window_half_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         phase_ff        <= PH_SAMPLE;
         in_record_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         act_len_ff      <= '0;
         act_half_ff     <= '0;
         span_ff         <= SPAN_W'(1);
         samples_seen_ff <= '0;
         deriv_seen_ff   <= '0;
         prod_seen_ff    <= '0;
         ring_ff         <= '0;
         running_sum_ff  <= '0;
         flush_left_ff   <= '0;
         k_ff            <= '0;
         div_cnt_ff      <= '0;
         last_ff         <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  x_ff     <= req_sample;
                  last_ff  <= req_last;
                  phase_ff <= PH_SAMPLE;
                  state_ff <= ST_DIFF;
                  if (!in_record_ff) begin
                     in_record_ff    <= 1'b1;
                     act_len_ff      <= len_sat;
                     act_half_ff     <= half_sat;
                     span_ff         <= {half_sat, 1'b1};
                     samples_seen_ff <= '0;
                     deriv_seen_ff   <= '0;
                     prod_seen_ff    <= '0;
                     ring_ff         <= '0;
                     running_sum_ff  <= '0;
                     for (int i = 0; i < qrsef_pkg::TAPS; i++) begin
                        samp_ff[i] <= '0;
                     end
                     for (int i = 0; i < MAX_PRODUCT_LEN; i++) begin
                        dl_ff[i] <= '0;
                     end
                  end
               end
            end
            ST_DIFF: begin
               samp_ff[0] <= x_ff;
               for (int i = 1; i < qrsef_pkg::TAPS; i++) begin
                  samp_ff[i] <= samp_ff[i-1];
               end
               d_ff <= d_in;
               if (samples_seen_ff == qrsef_pkg::SEEN_W'(qrsef_pkg::TAP_MID)) begin
                  state_ff <= ST_PSHIFT;
               end else begin
                  samples_seen_ff <= samples_seen_ff + 1'b1;
                  state_ff        <= ST_SEQ;
               end
            end
            ST_PSHIFT: begin
               dl_ff[0] <= d_ff;
               for (int i = 1; i < MAX_PRODUCT_LEN; i++) begin
                  dl_ff[i] <= dl_ff[i-1];
               end
               jp_ff <= deriv_seen_ff;
               if (deriv_seen_ff != LW'(MAX_PRODUCT_LEN)) begin
                  deriv_seen_ff <= deriv_seen_ff + 1'b1;
               end
               mag_ff <= VW'(1);
               k_ff   <= '0;
               if (deriv_seen_ff >= half_len) begin
                  state_ff <= ST_PMUL;
               end else begin
                  state_ff <= ST_SEQ;
               end
            end
            ST_PMUL: begin
               if (k_ff <= jp_ff) begin
                  mag_ff <= mag_in;
               end
               k_ff <= k_ff + 1'b1;
               if (k_ff == act_len_ff - 1'b1) begin
                  state_ff <= ST_INT_RD;
               end
            end
            ST_INT_RD: begin
               state_ff <= ST_INT_SUM;
            end
            ST_INT_SUM: begin
               running_sum_ff <= sum_in;
               ring_ff        <= ring_ff + 1'b1;
               if (prod_seen_ff != span_ff) begin
                  prod_seen_ff <= prod_seen_ff + 1'b1;
               end
               quot_ff    <= DIV_W'(sum_in);
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               if (prod_seen_ff >= SPAN_W'(act_half_ff)) begin
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_SEQ;
               end
            end
            ST_DIV: begin
               quot_ff    <= quot_in;
               rem_ff     <= rem_in;
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DCW'(DIV_STEPS - 1)) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= quot_ff[VW-1:0];
                  rsp_last_ff  <= fin;
                  state_ff     <= ST_SEQ;
               end
            end
            ST_SEQ: begin
               priority if (phase_ff == PH_SAMPLE && !last_ff) begin
                  state_ff <= ST_IDLE;
               end else if (phase_ff == PH_SAMPLE) begin
                  phase_ff      <= PH_DIFF;
                  flush_left_ff <= CNT_W'(qrsef_pkg::TAP_MID - 1);
                  x_ff          <= '0;
                  state_ff      <= ST_DIFF;
               end else if (phase_ff == PH_DIFF && flush_left_ff != '0) begin
                  flush_left_ff <= flush_left_ff - 1'b1;
                  x_ff          <= '0;
                  state_ff      <= ST_DIFF;
               end else if (phase_ff == PH_DIFF && half_len != '0) begin
                  phase_ff      <= PH_PROD;
                  flush_left_ff <= CNT_W'(half_len) - CNT_W'(1);
                  d_ff          <= DW'(1);
                  state_ff      <= ST_PSHIFT;
               end else if (phase_ff == PH_PROD && flush_left_ff != '0) begin
                  flush_left_ff <= flush_left_ff - 1'b1;
                  d_ff          <= DW'(1);
                  state_ff      <= ST_PSHIFT;
               end else if ((phase_ff == PH_DIFF || phase_ff == PH_PROD)
                            && act_half_ff != '0) begin
                  phase_ff      <= PH_INT;
                  flush_left_ff <= CNT_W'(act_half_ff) - CNT_W'(1);
                  mag_ff        <= '0;
                  state_ff      <= ST_INT_RD;
               end else if (phase_ff == PH_INT && flush_left_ff != '0) begin
                  flush_left_ff <= flush_left_ff - 1'b1;
                  mag_ff        <= '0;
                  state_ff      <= ST_INT_RD;
               end else begin
                  in_record_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // The window read and the write of the new entry never hit the same RAM word.
   a_rd_wr_apart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INT_RD) |-> (rd_addr != ring_ff))
      else $error("window read and write collide");

   a_ring_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INT_SUM) |=> (ring_ff == $past(ring_ff) + AW'(1)))
      else $error("ring pointer did not advance by one");

   a_record_close: assert property (@(posedge clock) disable iff (reset)
      $fell(in_record_ff) |-> (state_ff == ST_IDLE && $past(last_ff)))
      else $error("record closed outside a flush");

   a_pending_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_OUT))
      else $error("result dropped while output stage is full");

endmodule
